[hw/rtl/rc4_pkg.sv]
// Shared types and constants for the RC4 stream cipher.
package rc4_pkg;

  localparam int PERM_SIZE     = 256;
  localparam int KEY_BYTES_DEF = 32;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_RD,
    ST_KS_SUM,
    ST_KS_WR_N,
    ST_KS_WR_ACC,
    ST_DT_RD_I,
    ST_DT_RD_J,
    ST_DT_WR_I,
    ST_DT_WR_J,
    ST_DT_OUT
  } state_e;

  typedef struct packed {
    logic       clr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } perm_req_t;

endpackage

[hw/rtl/rc4_perm_mem.sv]
// Permutation table: write-first RAM with per-entry valid bits, unwritten entries read as their index.
module rc4_perm_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rc4_pkg::perm_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0]                   mem_q [rc4_pkg::PERM_SIZE];
  logic [rc4_pkg::PERM_SIZE-1:0] vld_q;
  logic [7:0]                   rdata_q;
  logic [7:0]                   raddr_q;
  logic                         rvld_q;
  logic                         hit;

  assign hit = req_i.we && (req_i.waddr == req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= hit ? req_i.wdata : mem_q[req_i.raddr];
    raddr_q <= req_i.raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= hit | vld_q[req_i.raddr];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : raddr_q;

endmodule

[hw/rtl/rc4_stream_cipher_top.sv]
// RC4 stream cipher top level: key buffer, sequencer and keystream datapath.
//
// Input channel (in_valid_i / in_ready_o) carries one word: func_i, byte_in_i, key_last_i.
// A key word (func_i = 0) is buffered; buffer overflow drops the byte. A key word with
// key_last_i set starts the key schedule over the permutation table.
// A data word (func_i = 1) returns one word on the output channel
// (out_valid_o / out_ready_i): byte_in_i XOR the next keystream byte.
// Sequencing, set by the one read port and one write port of the permutation RAM:
//   key word without key_last_i: taken in idle, no result.
//   key word with key_last_i: ST_KS_RD, then ST_KS_SUM, ST_KS_WR_N, ST_KS_WR_ACC for
//   each of the 256 table entries, no result.
//   data word: ST_DT_RD_I, ST_DT_RD_J, ST_DT_WR_I, ST_DT_WR_J, ST_DT_OUT; result registered.
// in_ready_o is high only while the sequencer is idle.
// Reset restores the identity permutation (valid bits cleared at once), clears both
// stream indices and empties the key buffer.
// A stalled receiver holds the result in the output register; the block keeps taking
// words until a second result is ready, then waits for the register to drain.
module rc4_stream_cipher_top #(
  parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] byte_in_i,
  input  logic       key_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o
);

  localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int CW = $clog2(KEY_BYTES + 1);

  rc4_pkg::state_e    state_q, state_d;
  rc4_pkg::perm_req_t preq;
  logic [7:0]         rd;

  logic [7:0]  i_q, i_d, j_q, j_d, n_q, n_d, acc_q, acc_d;
  logic [7:0]  sa_q, sa_d, sb_q, sb_d, byte_q, byte_d;
  logic [KW-1:0] k_q, k_d, k_wrap, kaddr;
  logic [CW-1:0] cnt_q, cnt_d, len_q, len_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [7:0]  kmem_q [KEY_BYTES];
  logic [7:0]  krd_q;
  logic        in_acc, room, kwe, slot_free;
  logic [7:0]  acc_sum;

  assign in_acc    = in_valid_i && in_ready_o;
  assign room      = cnt_q < CW'(KEY_BYTES);
  assign kwe       = in_acc && (func_i == rc4_pkg::FUNC_KEY) && room;
  assign slot_free = !out_valid_q || out_ready_i;
  assign k_wrap    = ((CW'(k_q) + CW'(1)) == len_q) ? '0 : k_q + KW'(1);
  assign kaddr     = (state_q == rc4_pkg::ST_KS_WR_ACC) ? k_wrap : k_q;
  assign acc_sum   = acc_q + rd + krd_q;

  always_ff @(posedge clk_i) begin
    if (kwe) begin
      kmem_q[cnt_q[KW-1:0]] <= byte_in_i;
    end
    krd_q <= kmem_q[kaddr];
  end

  rc4_perm_mem u_perm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (preq),
    .rdata_o(rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (func_i == rc4_pkg::FUNC_DATA) begin
            state_d = rc4_pkg::ST_DT_RD_I;
          end else if (key_last_i) begin
            state_d = rc4_pkg::ST_KS_RD;
          end
        end
      end
      rc4_pkg::ST_KS_RD:     state_d = rc4_pkg::ST_KS_SUM;
      rc4_pkg::ST_KS_SUM:    state_d = rc4_pkg::ST_KS_WR_N;
      rc4_pkg::ST_KS_WR_N:   state_d = rc4_pkg::ST_KS_WR_ACC;
      rc4_pkg::ST_KS_WR_ACC: begin
        state_d = (n_q == 8'hFF) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KS_SUM;
      end
      rc4_pkg::ST_DT_RD_I:   state_d = rc4_pkg::ST_DT_RD_J;
      rc4_pkg::ST_DT_RD_J:   state_d = rc4_pkg::ST_DT_WR_I;
      rc4_pkg::ST_DT_WR_I:   state_d = rc4_pkg::ST_DT_WR_J;
      rc4_pkg::ST_DT_WR_J:   state_d = rc4_pkg::ST_DT_OUT;
      rc4_pkg::ST_DT_OUT: begin
        if (slot_free) begin
          state_d = rc4_pkg::ST_IDLE;
        end
      end
      default: state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    preq        = '0;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    k_d         = k_q;
    acc_d       = acc_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    byte_d      = byte_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    in_ready_o  = 1'b0;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          byte_d = byte_in_i;
          if (func_i == rc4_pkg::FUNC_KEY) begin
            if (key_last_i) begin
              len_d    = room ? cnt_q + CW'(1) : cnt_q;
              cnt_d    = '0;
              preq.clr = 1'b1;
              n_d      = '0;
              k_d      = '0;
              acc_d    = '0;
            end else if (room) begin
              cnt_d = cnt_q + CW'(1);
            end
          end
        end
      end
      rc4_pkg::ST_KS_RD: begin
        preq.raddr = n_q;
      end
      rc4_pkg::ST_KS_SUM: begin
        sa_d       = rd;
        acc_d      = acc_sum;
        preq.raddr = acc_sum;
      end
      rc4_pkg::ST_KS_WR_N: begin
        preq.we    = 1'b1;
        preq.waddr = n_q;
        preq.wdata = rd;
      end
      rc4_pkg::ST_KS_WR_ACC: begin
        preq.we    = 1'b1;
        preq.waddr = acc_q;
        preq.wdata = sa_q;
        preq.raddr = n_q + 8'd1;
        n_d        = n_q + 8'd1;
        k_d        = k_wrap;
        if (n_q == 8'hFF) begin
          i_d = '0;
          j_d = '0;
        end
      end
      rc4_pkg::ST_DT_RD_I: begin
        preq.raddr = i_q + 8'd1;
        i_d        = i_q + 8'd1;
      end
      rc4_pkg::ST_DT_RD_J: begin
        sa_d       = rd;
        j_d        = j_q + rd;
        preq.raddr = j_q + rd;
      end
      rc4_pkg::ST_DT_WR_I: begin
        sb_d       = rd;
        preq.we    = 1'b1;
        preq.waddr = i_q;
        preq.wdata = rd;
      end
      rc4_pkg::ST_DT_WR_J: begin
        preq.we    = 1'b1;
        preq.waddr = j_q;
        preq.wdata = sa_q;
        preq.raddr = sa_q + sb_q;
      end
      rc4_pkg::ST_DT_OUT: begin
        preq.raddr = sa_q + sb_q;
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte_q ^ rd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      k_q         <= k_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q       <= sa_d;
    sb_q       <= sb_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = out_byte_q;

endmodule
